@@ rtl/core/dotted_decimal_address_validator_defines.svh @@
// Assertion macros shared by the address validator RTL.
// Needs nothing else; files that assert include it by name.
`ifndef DOTTED_DECIMAL_ADDRESS_VALIDATOR_DEFINES_SVH
`define DOTTED_DECIMAL_ADDRESS_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DDAV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DDAV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/dda_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the dotted-decimal address validator.
// Has no dependencies.
package dda_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 9;
   localparam int unsigned TOTAL_W = 3;
   localparam int unsigned PROD_W  = 13;

   localparam logic [CHAR_W-1:0]  SEPARATOR_RESET = 8'h40;
   localparam logic [CHAR_W-1:0]  FIELD_MAX_RESET = 8'd255;
   localparam logic [TOTAL_W-1:0] FIELDS_REQ_RESET = 3'd4;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;

   localparam logic [VALUE_W-1:0] VALUE_SAT = 9'd511;
   localparam logic [TOTAL_W-1:0] TOTAL_SAT = 3'd7;

   typedef enum logic [1:0] {
      CSR_SEPARATOR  = 2'd0,
      CSR_FIELD_MAX  = 2'd1,
      CSR_FIELDS_REQ = 2'd2
   } csr_index_type;

endpackage

@@ rtl/core/dotted_decimal_address_validator.sv @@
`timescale 1ns / 1ps
// Dotted-decimal address validator: checks a character stream word by word.
// Depends on dda_pkg and dotted_decimal_address_validator_defines.svh.
//
//   Channel | Direction | Beat contents
//   --------+-----------+----------------------------------------------
//   req_    | in        | tdata[7:0] char_in, tlast word_end
//   rsp_    | out       | tdata[0] address_ok, tdata[7:1] zero
//   csr_    | in        | index 0 separator, 1 field max, 2 field count
//
// One character beat is taken every cycle while req_tready is high; a word's
// verdict reaches rsp_ through the input register and the result register.
// Each beat passes the input register, then one update of the word state that
// feeds the result register.
// Reset is synchronous; there is no clearing pass.
// While rsp_tready is low a waiting verdict holds; a last character then
// waits in the input register, and req_tready drops until the verdict is taken.
`include "dotted_decimal_address_validator_defines.svh"

module dotted_decimal_address_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] address_ok, [7:1] zero
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   logic [dda_pkg::CHAR_W-1:0]  separator_ff;
   logic [dda_pkg::CHAR_W-1:0]  field_max_ff;
   logic [dda_pkg::TOTAL_W-1:0] fields_req_ff;

   logic                        s1_valid_ff, s1_valid_in;
   logic [dda_pkg::CHAR_W-1:0]  s1_char_ff;
   logic                        s1_last_ff;
   logic                        s1_fire;
   logic                        req_accept;

   logic [dda_pkg::VALUE_W-1:0] field_value_ff, field_value_in;
   logic [dda_pkg::TOTAL_W-1:0] field_total_ff, field_total_in;
   logic                        has_digit_ff, has_digit_in;
   logic                        lead_zero_ff, lead_zero_in;
   logic                        word_bad_ff, word_bad_in;

   logic [dda_pkg::VALUE_W-1:0] value_n;
   logic [dda_pkg::TOTAL_W-1:0] total_n;
   logic                        has_digit_n, lead_zero_n, bad_n;
   logic                        is_sep, is_digit;
   logic [3:0]                  digit;
   logic [dda_pkg::PROD_W-1:0]  prod;
   logic                        word_ok;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff  <= dda_pkg::SEPARATOR_RESET;
         field_max_ff  <= dda_pkg::FIELD_MAX_RESET;
         fields_req_ff <= dda_pkg::FIELDS_REQ_RESET;
      end else if (csr_valid) begin
         unique case (dda_pkg::csr_index_type'(csr_index))
            dda_pkg::CSR_SEPARATOR:  separator_ff  <= csr_data;
            dda_pkg::CSR_FIELD_MAX:  field_max_ff  <= csr_data;
            dda_pkg::CSR_FIELDS_REQ: fields_req_ff <= csr_data[dda_pkg::TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign s1_fire    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // The separator wins over a digit when both match the same byte.
   assign is_sep   = (s1_char_ff == separator_ff);
   assign is_digit = !is_sep && (s1_char_ff >= dda_pkg::CHAR_ZERO)
                     && (s1_char_ff <= dda_pkg::CHAR_NINE);
   assign digit    = s1_char_ff[3:0];
   assign prod     = {1'b0, field_value_ff, 3'b000} + {3'b000, field_value_ff, 1'b0}
                     + {{(dda_pkg::PROD_W-4){1'b0}}, digit};

   always_comb begin
      value_n     = field_value_ff;
      total_n     = field_total_ff;
      has_digit_n = has_digit_ff;
      lead_zero_n = lead_zero_ff;
      bad_n       = word_bad_ff;
      priority if (is_sep) begin
         if (!has_digit_ff || field_total_ff == dda_pkg::TOTAL_SAT) begin
            bad_n = 1'b1;
         end
         if (field_total_ff != dda_pkg::TOTAL_SAT) begin
            total_n = field_total_ff + 3'd1;
         end
         value_n     = '0;
         has_digit_n = 1'b0;
         lead_zero_n = 1'b0;
      end else if (is_digit) begin
         if (lead_zero_ff) begin
            bad_n = 1'b1;
         end
         lead_zero_n = !has_digit_ff && (digit == 4'd0);
         if (prod > {4'b0000, dda_pkg::VALUE_SAT}) begin
            value_n = dda_pkg::VALUE_SAT;
         end else begin
            value_n = prod[dda_pkg::VALUE_W-1:0];
         end
         has_digit_n = 1'b1;
         if (value_n > {1'b0, field_max_ff}) begin
            bad_n = 1'b1;
         end
      end else begin
         bad_n = 1'b1;
      end
   end

   assign word_ok = !bad_n && has_digit_n
                    && ({1'b0, total_n} + 4'd1 == {1'b0, fields_req_ff});

   always_comb begin
      field_value_in = field_value_ff;
      field_total_in = field_total_ff;
      has_digit_in   = has_digit_ff;
      lead_zero_in   = lead_zero_ff;
      word_bad_in    = word_bad_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            field_value_in = '0;
            field_total_in = '0;
            has_digit_in   = 1'b0;
            lead_zero_in   = 1'b0;
            word_bad_in    = 1'b0;
         end else begin
            field_value_in = value_n;
            field_total_in = total_n;
            has_digit_in   = has_digit_n;
            lead_zero_in   = lead_zero_n;
            word_bad_in    = bad_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_value_ff <= '0;
         field_total_ff <= '0;
         has_digit_ff   <= 1'b0;
         lead_zero_ff   <= 1'b0;
         word_bad_ff    <= 1'b0;
      end else begin
         field_value_ff <= field_value_in;
         field_total_ff <= field_total_in;
         has_digit_ff   <= has_digit_in;
         lead_zero_ff   <= lead_zero_in;
         word_bad_ff    <= word_bad_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = word_ok;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_ok_ff};

   `DDAV_ASSERT_NEXT(a_word_end_clears, clock, reset, s1_fire && s1_last_ff,
      field_total_ff == '0 && !word_bad_ff && !has_digit_ff && !lead_zero_ff,
      "Word state not cleared after the last character.")
   `DDAV_ASSERT_NEXT(a_verdict_loaded, clock, reset, s1_fire && s1_last_ff,
      rsp_valid_ff, "Verdict not presented after the last character.")
   `DDAV_ASSERT_NOW(a_lead_zero_value, clock, reset, lead_zero_ff,
      has_digit_ff && field_value_ff == '0, "Leading-zero flag with a nonzero field.")
   `DDAV_ASSERT_NOW(a_empty_field_value, clock, reset, !has_digit_ff,
      field_value_ff == '0, "Field value held without any digit.")

endmodule
